// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. They sample on clock and are disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge outside reset.
`define FUPD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be true outside reset.
`define FUPD_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// File: sv/fupd_pkg.sv
// ----------------------------------------------------------------------------
// fupd_pkg
// Types, constants and character helpers for the file URI path decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fupd_pkg;

   typedef logic [7:0] char_type;

   localparam int              MAX_OUT_W     = 12;
   localparam logic [11:0]     MAX_OUT_RESET = 12'd1023;
   localparam int              MAX_RES       = 34;
   localparam int              RESN_W        = 6;
   localparam int              SCHEME_LEN    = 7;
   localparam int              LOCAL_LEN     = 10;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_PCT   = 8'h25;
   localparam char_type CH_SLASH = 8'h2F;
   localparam char_type CH_D0    = 8'h30;
   localparam char_type CH_D9    = 8'h39;
   localparam char_type CH_UC_A  = 8'h41;
   localparam char_type CH_UC_F  = 8'h46;
   localparam char_type CH_LC_A  = 8'h61;
   localparam char_type CH_LC_F  = 8'h66;

   // escape tracking; ESC_TAIL is only used while flushing "%x" at end of URI
   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_ONE,
      ESC_TWO,
      ESC_TAIL
   } esc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DECODE,
      OP_HOST_ADD,
      OP_FLUSH,
      OP_CLOSE_STEP,
      OP_CLOSE_URI
   } op_type;

   typedef struct packed {
      op_type   op;
      logic     from_host;   // decode byte comes from host buffer read data
      char_type data;
      logic     host_clr;
   } cmd_type;

   typedef struct packed {
      logic dec_rdy;
      logic out_free;
      logic esc_nz;
      logic host_over;
      logic host_empty;
      logic host_last;
   } stat_type;

   typedef struct packed {
      char_type out_byte;
      logic     byte_valid;
      logic     last_out;
      logic     nonempty;
      logic     status;
   } rsp_item_type;

   // "file://"
   function automatic char_type scheme_char(input logic [3:0] i);
      char_type c;
      case (i)
         4'd0:    c = 8'h66;
         4'd1:    c = 8'h69;
         4'd2:    c = 8'h6C;
         4'd3:    c = 8'h65;
         4'd4:    c = 8'h3A;
         4'd5:    c = CH_SLASH;
         4'd6:    c = CH_SLASH;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // "localhost/"
   function automatic char_type local_char(input logic [3:0] i);
      char_type c;
      case (i)
         4'd0:    c = 8'h6C;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h63;
         4'd3:    c = 8'h61;
         4'd4:    c = 8'h6C;
         4'd5:    c = 8'h68;
         4'd6:    c = 8'h6F;
         4'd7:    c = 8'h73;
         4'd8:    c = 8'h74;
         4'd9:    c = CH_SLASH;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic logic hex_ok(input char_type c);
      return (c inside {[CH_D0:CH_D9], [CH_UC_A:CH_UC_F], [CH_LC_A:CH_LC_F]});
   endfunction

   // digits map from the low nibble, letters are low nibble plus nine
   function automatic logic [3:0] hex_val(input char_type c);
      logic [3:0] v;
      if (c inside {[CH_D0:CH_D9]}) begin
         v = c[3:0];
      end else begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// File: sv/fupd_if.sv
// ----------------------------------------------------------------------------
// fupd_if
// Valid/ready stream interfaces for URI bytes in and path results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fupd_req_if;
   logic               valid;
   logic               ready;
   fupd_pkg::char_type in_byte;
   logic               in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface fupd_rsp_if;
   logic               valid;
   logic               ready;
   fupd_pkg::char_type out_byte;
   logic               byte_valid;
   logic               last_out;
   logic               nonempty;
   logic               status;

   modport source (output valid, output out_byte, output byte_valid, output last_out,
                   output nonempty, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last_out,
                   input nonempty, input status, output ready);
endinterface

// File: sv/fupd_dp.sv
// ----------------------------------------------------------------------------
// fupd_dp
// Datapath: percent decoder with replay, host buffer, length limit,
// result staging and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fupd_dp #(
   parameter int HOST_MAX = 32,
   parameter int HIDX_W   = 5,
   parameter int HLEN_W   = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [11:0]            csr_wr_data,
   input  fupd_pkg::cmd_type      cmd,
   input  logic [HIDX_W-1:0]      rd_idx,
   output fupd_pkg::stat_type     st,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fupd_pkg::rsp_item_type rsp_item
);

   localparam int RESN_W = fupd_pkg::RESN_W;

   logic [11:0]            max_len_ff, max_len_in;
   fupd_pkg::esc_type      esc_ff, esc_in;
   fupd_pkg::char_type     e0_ff, e0_in;
   fupd_pkg::char_type     rq_ff [2];
   fupd_pkg::char_type     rq_in [2];
   logic [1:0]             rcnt_ff, rcnt_in;
   logic [11:0]            emitted_ff, emitted_in;
   logic                   fnz_ff, fnz_in;
   logic [RESN_W-1:0]      resn_ff, resn_in;
   logic [HLEN_W-1:0]      hlen_ff, hlen_in;
   logic                   hover_ff, hover_in;
   fupd_pkg::char_type     host_mem [HOST_MAX];
   fupd_pkg::char_type     rdata_ff;
   logic                   pend_v_ff, pend_v_in;
   fupd_pkg::char_type     pend_b_ff, pend_b_in;
   logic                   out_v_ff, out_v_in;
   fupd_pkg::rsp_item_type out_ff, out_in;

   logic                   out_free, room, busy, dec_en;
   fupd_pkg::char_type     dec_b, emit_b;
   logic                   emit_req, emit_ok, host_we, out_load;
   fupd_pkg::rsp_item_type out_new;

   always_comb begin
      out_free = !out_v_ff || rsp_ready;
      room     = !pend_v_ff || out_free;
      busy     = (rcnt_ff != 2'd0);
      dec_en   = busy ? room : (cmd.op == fupd_pkg::OP_DECODE);
      dec_b    = busy ? rq_ff[0] : (cmd.from_host ? rdata_ff : cmd.data);

      max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;
      esc_in     = esc_ff;
      e0_in      = e0_ff;
      rq_in      = rq_ff;
      rcnt_in    = rcnt_ff;
      emitted_in = emitted_ff;
      fnz_in     = fnz_ff;
      resn_in    = resn_ff;
      hlen_in    = hlen_ff;
      hover_in   = hover_ff;
      pend_v_in  = pend_v_ff;
      pend_b_in  = pend_b_ff;
      out_v_in   = out_v_ff && !rsp_ready;
      out_in     = out_ff;
      emit_req   = 1'b0;
      emit_b     = pend_b_ff;
      host_we    = 1'b0;
      out_load   = 1'b0;
      out_new    = '{out_byte: pend_b_ff, byte_valid: 1'b1, last_out: 1'b0,
                     nonempty: 1'b0, status: 1'b0};

      // replay queue drains one byte per cycle after a bad escape, while there is room for the result
      if (busy && room) begin
         rq_in[0] = rq_ff[1];
         rcnt_in  = rcnt_ff - 2'd1;
      end

      if (dec_en) begin
         case (esc_ff)
            fupd_pkg::ESC_NONE: begin
               if (dec_b == fupd_pkg::CH_PCT) begin
                  esc_in = fupd_pkg::ESC_ONE;
               end else begin
                  emit_req = 1'b1;
                  emit_b   = dec_b;
               end
            end
            fupd_pkg::ESC_ONE: begin
               e0_in  = dec_b;
               esc_in = fupd_pkg::ESC_TWO;
            end
            fupd_pkg::ESC_TWO: begin
               esc_in   = fupd_pkg::ESC_NONE;
               emit_req = 1'b1;
               if (fupd_pkg::hex_ok(e0_ff) && fupd_pkg::hex_ok(dec_b)) begin
                  emit_b = {fupd_pkg::hex_val(e0_ff), fupd_pkg::hex_val(dec_b)};
               end else begin
                  // literal '%', then both bytes go round again
                  emit_b   = fupd_pkg::CH_PCT;
                  rq_in[0] = e0_ff;
                  rq_in[1] = dec_b;
                  rcnt_in  = 2'd2;
               end
            end
            default: ;
         endcase
      end

      if (cmd.op == fupd_pkg::OP_FLUSH) begin
         case (esc_ff)
            fupd_pkg::ESC_ONE: begin
               emit_req = 1'b1;
               emit_b   = fupd_pkg::CH_PCT;
               esc_in   = fupd_pkg::ESC_NONE;
            end
            fupd_pkg::ESC_TWO: begin
               emit_req = 1'b1;
               emit_b   = fupd_pkg::CH_PCT;
               esc_in   = fupd_pkg::ESC_TAIL;
            end
            fupd_pkg::ESC_TAIL: begin
               emit_req = 1'b1;
               emit_b   = e0_ff;
               esc_in   = fupd_pkg::ESC_NONE;
            end
            default: ;
         endcase
      end

      emit_ok = emit_req && (emitted_ff < max_len_ff)
                && (resn_ff < RESN_W'(fupd_pkg::MAX_RES));
      if (emit_ok) begin
         if (emitted_ff == 12'd0 && emit_b != fupd_pkg::CH_NUL) begin
            fnz_in = 1'b1;
         end
         emitted_in = emitted_ff + 12'd1;
         resn_in    = resn_ff + RESN_W'(1);
         out_load   = pend_v_ff;
         pend_v_in  = 1'b1;
         pend_b_in  = emit_b;
      end

      if (cmd.host_clr) begin
         hlen_in  = '0;
         hover_in = 1'b0;
      end

      case (cmd.op)
         fupd_pkg::OP_HOST_ADD: begin
            if (hlen_ff < HLEN_W'(HOST_MAX)) begin
               host_we = 1'b1;
               hlen_in = hlen_ff + HLEN_W'(1);
            end else begin
               hover_in = 1'b1;
            end
         end
         fupd_pkg::OP_CLOSE_STEP: begin
            out_load  = pend_v_ff;
            pend_v_in = 1'b0;
            resn_in   = '0;
         end
         fupd_pkg::OP_CLOSE_URI: begin
            out_load           = 1'b1;
            out_new.out_byte   = pend_v_ff ? pend_b_ff : fupd_pkg::CH_NUL;
            out_new.byte_valid = pend_v_ff;
            out_new.last_out   = 1'b1;
            out_new.nonempty   = fnz_ff;
            out_new.status     = hover_ff;
            pend_v_in          = 1'b0;
            resn_in            = '0;
            esc_in             = fupd_pkg::ESC_NONE;
            e0_in              = fupd_pkg::CH_NUL;
            emitted_in         = '0;
            fnz_in             = 1'b0;
            hlen_in            = '0;
            hover_in           = 1'b0;
         end
         default: ;
      endcase

      if (out_load) begin
         out_v_in = 1'b1;
         out_in   = out_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= fupd_pkg::MAX_OUT_RESET;
         esc_ff     <= fupd_pkg::ESC_NONE;
         rcnt_ff    <= 2'd0;
         emitted_ff <= '0;
         fnz_ff     <= 1'b0;
         resn_ff    <= '0;
         hlen_ff    <= '0;
         hover_ff   <= 1'b0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         esc_ff     <= esc_in;
         rcnt_ff    <= rcnt_in;
         emitted_ff <= emitted_in;
         fnz_ff     <= fnz_in;
         resn_ff    <= resn_in;
         hlen_ff    <= hlen_in;
         hover_ff   <= hover_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
      e0_ff     <= e0_in;
      rq_ff     <= rq_in;
      pend_b_ff <= pend_b_in;
      out_ff    <= out_in;
   end

   // host buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (host_we) begin
         host_mem[hlen_ff[HIDX_W-1:0]] <= cmd.data;
      end
      rdata_ff <= host_mem[rd_idx];
   end

   always_comb begin
      st.dec_rdy    = room && !busy;
      st.out_free   = out_free;
      st.esc_nz     = (esc_ff != fupd_pkg::ESC_NONE);
      st.host_over  = hover_ff;
      st.host_empty = (hlen_ff == '0);
      st.host_last  = ((HLEN_W'(rd_idx) + HLEN_W'(1)) == hlen_ff);
   end

   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

   `FUPD_ASSERT(a_pend_no_clobber, (emit_ok && pend_v_ff) |-> out_free, "staged beat lost")
   `FUPD_ASSERT(a_close_gives_last, (cmd.op == fupd_pkg::OP_CLOSE_URI) |=> (out_v_ff && out_ff.last_out), "no final beat")
   `FUPD_ASSERT_NEVER(a_res_cap, resn_ff > RESN_W'(fupd_pkg::MAX_RES), "result count past cap")

endmodule

// File: sv/fupd_ctrl.sv
// ----------------------------------------------------------------------------
// fupd_ctrl
// Controller: prefix and host matching, sequencing of decoder and host
// buffer commands per input byte and at end of URI.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fupd_ctrl #(
   parameter int HIDX_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fupd_pkg::char_type req_byte,
   input  logic               req_last,
   output fupd_pkg::cmd_type  cmd,
   input  fupd_pkg::stat_type st,
   output logic [HIDX_W-1:0]  rd_idx
);

   localparam int IDX_W = (HIDX_W > 4) ? HIDX_W : 4;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_LOCAL,
      PH_HOST,
      PH_PATH
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PFX,
      S_DEC_B,
      S_DEC_SLASH,
      S_LHOST,
      S_HADD_B,
      S_CLOSE,
      S_FIN,
      S_FTXT,
      S_FHRD,
      S_FHDEC,
      S_FESC
   } state_type;

   state_type          state_ff, state_in, end_st;
   phase_type          phase_ff, phase_in;
   logic [3:0]         mp_ff, mp_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [3:0]         rep_ff, rep_in;
   fupd_pkg::char_type b_ff, b_in;
   logic               last_ff, last_in;
   logic [3:0]         idx_lo;
   logic               txt_last;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      mp_in    = mp_ff;
      idx_in   = idx_ff;
      rep_in   = rep_ff;
      b_in     = b_ff;
      last_in  = last_ff;

      cmd.op        = fupd_pkg::OP_NONE;
      cmd.from_host = 1'b0;
      cmd.data      = b_ff;
      cmd.host_clr  = 1'b0;

      req_ready = (state_ff == S_IDLE);
      idx_lo    = idx_ff[3:0];
      txt_last  = ((idx_lo + 4'd1) == rep_ff);
      end_st    = ((state_ff == S_IDLE) ? req_last : last_ff) ? S_FIN : S_CLOSE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               b_in    = req_byte;
               last_in = req_last;
               if (req_byte == fupd_pkg::CH_NUL) begin
                  state_in = S_FIN;
               end else begin
                  case (phase_ff)
                     PH_PREFIX: begin
                        if (req_byte == fupd_pkg::scheme_char(mp_ff)) begin
                           if (mp_ff == 4'(fupd_pkg::SCHEME_LEN - 1)) begin
                              phase_in = PH_LOCAL;
                              mp_in    = 4'd0;
                           end else begin
                              mp_in = mp_ff + 4'd1;
                           end
                           state_in = end_st;
                        end else begin
                           rep_in   = mp_ff;
                           idx_in   = '0;
                           phase_in = PH_PATH;
                           mp_in    = 4'd0;
                           state_in = (mp_ff != 4'd0) ? S_PFX : S_DEC_B;
                        end
                     end
                     PH_LOCAL: begin
                        if (req_byte == fupd_pkg::local_char(mp_ff)) begin
                           if (mp_ff == 4'(fupd_pkg::LOCAL_LEN - 1)) begin
                              mp_in    = 4'd0;
                              phase_in = PH_PATH;
                              state_in = S_DEC_SLASH;
                           end else begin
                              mp_in    = mp_ff + 4'd1;
                              state_in = end_st;
                           end
                        end else if (req_byte == fupd_pkg::CH_SLASH) begin
                           mp_in    = 4'd0;
                           phase_in = PH_PATH;
                           state_in = S_DEC_SLASH;
                        end else begin
                           rep_in   = mp_ff;
                           idx_in   = '0;
                           phase_in = PH_HOST;
                           mp_in    = 4'd0;
                           state_in = (mp_ff != 4'd0) ? S_LHOST : S_HADD_B;
                        end
                     end
                     PH_HOST: begin
                        if (req_byte == fupd_pkg::CH_SLASH) begin
                           phase_in = PH_PATH;
                           state_in = S_DEC_SLASH;
                        end else begin
                           state_in = S_HADD_B;
                        end
                     end
                     default: begin
                        state_in = S_DEC_B;
                     end
                  endcase
               end
            end
         end
         S_PFX: begin
            if (st.dec_rdy) begin
               cmd.op   = fupd_pkg::OP_DECODE;
               cmd.data = fupd_pkg::scheme_char(idx_lo);
               idx_in   = idx_ff + IDX_W'(1);
               if (txt_last) begin
                  state_in = S_DEC_B;
               end
            end
         end
         S_DEC_B: begin
            if (st.dec_rdy) begin
               cmd.op   = fupd_pkg::OP_DECODE;
               state_in = end_st;
            end
         end
         S_DEC_SLASH: begin
            if (st.dec_rdy) begin
               cmd.op       = fupd_pkg::OP_DECODE;
               cmd.data     = fupd_pkg::CH_SLASH;
               cmd.host_clr = 1'b1;
               state_in     = end_st;
            end
         end
         S_LHOST: begin
            cmd.op   = fupd_pkg::OP_HOST_ADD;
            cmd.data = fupd_pkg::local_char(idx_lo);
            idx_in   = idx_ff + IDX_W'(1);
            if (txt_last) begin
               state_in = S_HADD_B;
            end
         end
         S_HADD_B: begin
            cmd.op   = fupd_pkg::OP_HOST_ADD;
            state_in = end_st;
         end
         S_CLOSE: begin
            if (st.dec_rdy) begin
               cmd.op   = fupd_pkg::OP_CLOSE_STEP;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            idx_in = '0;
            rep_in = mp_ff;
            case (phase_ff)
               PH_PREFIX, PH_LOCAL: begin
                  state_in = (mp_ff != 4'd0) ? S_FTXT : S_FESC;
               end
               PH_HOST: begin
                  state_in = (st.host_over || st.host_empty) ? S_FESC : S_FHRD;
               end
               default: begin
                  state_in = S_FESC;
               end
            endcase
         end
         S_FTXT: begin
            if (st.dec_rdy) begin
               cmd.op   = fupd_pkg::OP_DECODE;
               cmd.data = (phase_ff == PH_LOCAL) ? fupd_pkg::local_char(idx_lo)
                                                 : fupd_pkg::scheme_char(idx_lo);
               idx_in   = idx_ff + IDX_W'(1);
               if (txt_last) begin
                  state_in = S_FESC;
               end
            end
         end
         S_FHRD: begin
            state_in = S_FHDEC;
         end
         S_FHDEC: begin
            if (st.dec_rdy) begin
               cmd.op        = fupd_pkg::OP_DECODE;
               cmd.from_host = 1'b1;
               idx_in        = idx_ff + IDX_W'(1);
               state_in      = st.host_last ? S_FESC : S_FHRD;
            end
         end
         S_FESC: begin
            if (st.dec_rdy) begin
               if (st.esc_nz) begin
                  cmd.op = fupd_pkg::OP_FLUSH;
               end else if (st.out_free) begin
                  cmd.op   = fupd_pkg::OP_CLOSE_URI;
                  phase_in = PH_PREFIX;
                  mp_in    = 4'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PREFIX;
         mp_ff    <= 4'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mp_ff    <= mp_in;
      end
      idx_ff  <= idx_in;
      rep_ff  <= rep_in;
      b_ff    <= b_in;
      last_ff <= last_in;
   end

   assign rd_idx = idx_ff[HIDX_W-1:0];

   `FUPD_ASSERT(a_idle_dp_drained, req_ready |-> st.dec_rdy, "byte taken with datapath busy")

endmodule

// File: sv/file_uri_percent_decoder_core.sv
// ----------------------------------------------------------------------------
// file_uri_percent_decoder_core - file URI to path decoder, top level
// Flow: a new URI byte is taken only with the controller back in idle, once the decode,
// replay bytes of a bad escape and localhost bytes moved to the host buffer are done.
// Path: a decoded byte waits in the staging register, then moves to the rsp register.
// End of URI: held prefix bytes, buffered host bytes and escape flush beats go out
// before the last beat; rsp stalls hold this back.
// Reset: synchronous, clears control state, max_out_len back to 1023.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Structure
//   fupd_ctrl : state machine. Holds the scheme/host match phase, latches the
//               accepted beat and issues one command per cycle, waiting while the
//               datapath is not ready (decode a byte, add a byte to the host
//               buffer, flush an open escape, close a step or close the URI).
//   fupd_dp   : percent decoder with a two-byte replay queue for bad escapes,
//               output length limit, per-step result cap, host buffer memory,
//               one staging register and the rsp output register.
//
// The staging register holds the newest decoded byte until the controller
// knows whether the step ends the URI; that beat then carries last_out,
// nonempty and status. If nothing was staged, an empty last beat is sent.
// The rsp register frees req from rsp: the next URI byte is accepted while
// a finished beat still waits for rsp_chan.ready.

module file_uri_percent_decoder_core #(
   parameter int HOST_MAX = 32
) (
   input  logic              clock,
   input  logic              reset,
   fupd_req_if.sink          req_chan,
   fupd_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [11:0]       csr_wr_data
);

   // host buffer index and fill-count widths
   localparam int HIDX_W = (HOST_MAX > 1) ? $clog2(HOST_MAX) : 1;
   localparam int HLEN_W = $clog2(HOST_MAX + 1);

   fupd_pkg::cmd_type      cmd;
   fupd_pkg::stat_type     st;
   logic [HIDX_W-1:0]      rd_idx;
   logic                   rsp_valid;
   fupd_pkg::rsp_item_type rsp_item;

   fupd_ctrl #(
      .HIDX_W (HIDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_byte  (req_chan.in_byte),
      .req_last  (req_chan.in_last),
      .cmd       (cmd),
      .st        (st),
      .rd_idx    (rd_idx)
   );

   fupd_dp #(
      .HOST_MAX (HOST_MAX),
      .HIDX_W   (HIDX_W),
      .HLEN_W   (HLEN_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .rd_idx      (rd_idx),
      .st          (st),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_item    (rsp_item)
   );

   // result beat out
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.out_byte   = rsp_item.out_byte;
   assign rsp_chan.byte_valid = rsp_item.byte_valid;
   assign rsp_chan.last_out   = rsp_item.last_out;
   assign rsp_chan.nonempty   = rsp_item.nonempty;
   assign rsp_chan.status     = rsp_item.status;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench - file URI path decoder core
// Feeds URI byte streams through the request channel and checks every result
// beat against a byte-level model of the decoder held in a scoreboard class.
// Covers the scheme and host stripping, percent escapes, the output length
// limit at several settings and the slashless host buffer with its overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: tracks the decoder state per URI and queues the beats that each
// accepted byte must produce.
class path_scoreboard #(int HOST_CAP = 32);

   typedef enum logic [1:0] {
      SCAN_SCHEME,
      SCAN_LOCAL,
      SCAN_HOST,
      SCAN_PATH
   } scan_type;

   logic [11:0]            out_limit;
   scan_type               scan;
   int unsigned            match_len;
   fupd_pkg::esc_type      esc_state;
   fupd_pkg::char_type     esc_hold;
   fupd_pkg::char_type     host_buf[HOST_CAP];
   int unsigned            host_cnt;
   bit                     host_lost;
   logic [11:0]            path_cnt;
   bit                     lead_nonzero;
   fupd_pkg::rsp_item_type step_q[$];
   fupd_pkg::rsp_item_type expected_q[$];

   function new();
      out_limit = fupd_pkg::MAX_OUT_RESET;
      restart_uri();
   endfunction

   function void restart_uri();
      scan         = SCAN_SCHEME;
      match_len    = 0;
      esc_state    = fupd_pkg::ESC_NONE;
      esc_hold     = fupd_pkg::CH_NUL;
      host_cnt     = 0;
      host_lost    = 1'b0;
      path_cnt     = '0;
      lead_nonzero = 1'b0;
   endfunction

   function fupd_pkg::char_type scheme_at(int unsigned i);
      logic [8*fupd_pkg::SCHEME_LEN-1:0] txt;
      txt = "file://";
      return txt[8 * (fupd_pkg::SCHEME_LEN - 1 - i) +: 8];
   endfunction

   function fupd_pkg::char_type local_at(int unsigned i);
      logic [8*fupd_pkg::LOCAL_LEN-1:0] txt;
      txt = "localhost/";
      return txt[8 * (fupd_pkg::LOCAL_LEN - 1 - i) +: 8];
   endfunction

   function int hex_nibble(fupd_pkg::char_type c);
      if (c >= fupd_pkg::CH_D0 && c <= fupd_pkg::CH_D9)
         return int'(c - fupd_pkg::CH_D0);
      if (c >= fupd_pkg::CH_LC_A && c <= fupd_pkg::CH_LC_F)
         return int'(c - fupd_pkg::CH_LC_A) + 10;
      if (c >= fupd_pkg::CH_UC_A && c <= fupd_pkg::CH_UC_F)
         return int'(c - fupd_pkg::CH_UC_A) + 10;
      return -1;
   endfunction

   function void push_beat(fupd_pkg::char_type b, logic vld);
      fupd_pkg::rsp_item_type r;
      if (step_q.size() >= fupd_pkg::MAX_RES) return;
      r.out_byte   = b;
      r.byte_valid = vld;
      r.last_out   = 1'b0;
      r.nonempty   = 1'b0;
      r.status     = 1'b0;
      step_q.push_back(r);
   endfunction

   // one path byte out, subject to the length limit and the per-step cap
   function void put_path_byte(fupd_pkg::char_type b);
      if (path_cnt >= out_limit || step_q.size() >= fupd_pkg::MAX_RES) return;
      if (path_cnt == 0 && b != fupd_pkg::CH_NUL) lead_nonzero = 1'b1;
      path_cnt++;
      push_beat(b, 1'b1);
   endfunction

   // byte handling outside a complete escape: open one, hold its first digit or pass the byte on
   function void plain_byte(fupd_pkg::char_type b);
      if (esc_state == fupd_pkg::ESC_NONE) begin
         if (b == fupd_pkg::CH_PCT) esc_state = fupd_pkg::ESC_ONE;
         else put_path_byte(b);
      end else begin
         esc_hold  = b;
         esc_state = fupd_pkg::ESC_TWO;
      end
   endfunction

   function void unescape(fupd_pkg::char_type b);
      int                 hi;
      int                 lo;
      fupd_pkg::char_type held;
      if (esc_state != fupd_pkg::ESC_TWO) begin
         plain_byte(b);
         return;
      end
      hi        = hex_nibble(esc_hold);
      lo        = hex_nibble(b);
      esc_state = fupd_pkg::ESC_NONE;
      if (hi >= 0 && lo >= 0) begin
         put_path_byte(fupd_pkg::char_type'((hi << 4) | lo));
      end else begin
         // bad escape: literal percent, then both bytes go round again
         held = esc_hold;
         put_path_byte(fupd_pkg::CH_PCT);
         plain_byte(held);
         plain_byte(b);
      end
   endfunction

   function void host_push(fupd_pkg::char_type b);
      if (host_cnt < HOST_CAP) begin
         host_buf[host_cnt] = b;
         host_cnt++;
      end else begin
         host_lost = 1'b1;
      end
   endfunction

   function void scan_byte(fupd_pkg::char_type b);
      case (scan)
         SCAN_SCHEME: begin
            if (match_len < fupd_pkg::SCHEME_LEN && b == scheme_at(match_len)) begin
               match_len++;
               if (match_len == fupd_pkg::SCHEME_LEN) begin
                  scan      = SCAN_LOCAL;
                  match_len = 0;
               end
            end else begin
               // not a file URI after all: held prefix bytes are path bytes
               for (int unsigned i = 0; i < match_len; i++) unescape(scheme_at(i));
               match_len = 0;
               scan      = SCAN_PATH;
               unescape(b);
            end
         end
         SCAN_LOCAL: begin
            if (match_len < fupd_pkg::LOCAL_LEN && b == local_at(match_len)) begin
               match_len++;
               if (match_len == fupd_pkg::LOCAL_LEN) begin
                  match_len = 0;
                  scan      = SCAN_PATH;
                  unescape(fupd_pkg::CH_SLASH);
               end
            end else if (b == fupd_pkg::CH_SLASH) begin
               match_len = 0;
               scan      = SCAN_PATH;
               unescape(fupd_pkg::CH_SLASH);
            end else begin
               for (int unsigned i = 0; i < match_len; i++) host_push(local_at(i));
               host_push(b);
               match_len = 0;
               scan      = SCAN_HOST;
            end
         end
         SCAN_HOST: begin
            if (b == fupd_pkg::CH_SLASH) begin
               host_cnt  = 0;
               host_lost = 1'b0;
               scan      = SCAN_PATH;
               unescape(fupd_pkg::CH_SLASH);
            end else begin
               host_push(b);
            end
         end
         default: unescape(b);
      endcase
   endfunction

   function void close_uri();
      bit                     lost;
      fupd_pkg::esc_type      open_esc;
      fupd_pkg::rsp_item_type tail;
      lost = 1'b0;
      case (scan)
         SCAN_SCHEME: for (int unsigned i = 0; i < match_len; i++) unescape(scheme_at(i));
         SCAN_LOCAL:  for (int unsigned i = 0; i < match_len; i++) unescape(local_at(i));
         SCAN_HOST: begin
            if (host_lost) lost = 1'b1;
            else for (int unsigned i = 0; i < host_cnt; i++) unescape(host_buf[i]);
         end
         default: ;
      endcase
      // an open escape goes out literally
      if (esc_state != fupd_pkg::ESC_NONE) begin
         open_esc  = esc_state;
         esc_state = fupd_pkg::ESC_NONE;
         put_path_byte(fupd_pkg::CH_PCT);
         if (open_esc == fupd_pkg::ESC_TWO) put_path_byte(esc_hold);
      end
      if (step_q.size() == 0) push_beat(fupd_pkg::CH_NUL, 1'b0);
      tail          = step_q.pop_back();
      tail.last_out = 1'b1;
      tail.nonempty = lead_nonzero;
      tail.status   = lost;
      step_q.push_back(tail);
      restart_uri();
   endfunction

   function void note_byte(fupd_pkg::char_type b, logic last);
      step_q.delete();
      if (b != fupd_pkg::CH_NUL) scan_byte(b);
      if (b == fupd_pkg::CH_NUL || last) close_uri();
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
   endfunction

   function bit check_beat(fupd_pkg::rsp_item_type got, output string msg);
      fupd_pkg::rsp_item_type want;
      if (expected_q.size() == 0) begin
         msg = $sformatf(" not expected: byte %h valid %b last %b",
                         got.out_byte, got.byte_valid, got.last_out);
         return 1'b0;
      end
      want = expected_q.pop_front();
      msg  = "";
      if (got.out_byte !== want.out_byte)
         msg = {msg, $sformatf(" out_byte %h want %h", got.out_byte, want.out_byte)};
      if (got.byte_valid !== want.byte_valid)
         msg = {msg, $sformatf(" byte_valid %b want %b", got.byte_valid, want.byte_valid)};
      if (got.last_out !== want.last_out)
         msg = {msg, $sformatf(" last_out %b want %b", got.last_out, want.last_out)};
      if (got.nonempty !== want.nonempty)
         msg = {msg, $sformatf(" nonempty %b want %b", got.nonempty, want.nonempty)};
      if (got.status !== want.status)
         msg = {msg, $sformatf(" status %b want %b", got.status, want.status)};
      return (msg.len() == 0);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module testbench;

   localparam int    HOST_CAP     = 32;
   localparam int    IDLE_LIMIT   = 2000;  // cycles without any beat
   localparam int    QUIET_CYCLES = 12;    // settle time after the last beat
   localparam int    RANDOM_ITEMS = 50;
   localparam int    PHASES       = 5;
   localparam string SCHEME_TEXT  = "file://";
   localparam string LOCAL_TEXT   = "localhost/";
   localparam string HEX_DIGITS   = "0123456789abcdefABCDEF";
   localparam string NON_HEX      = "gGzZ%/.~ ";

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;

   fupd_req_if req_chan();
   fupd_rsp_if rsp_chan();

   path_scoreboard #(.HOST_CAP(HOST_CAP)) sb;

   int                 fail_count = 0;
   int                 req_beats  = 0;
   int                 rsp_beats  = 0;
   bit                 req_steady = 1'b0;   // sender runs without gaps for this URI
   bit                 rsp_steady = 1'b0;   // receiver runs without stalls for a while
   fupd_pkg::char_type uri_q[$];            // URI being assembled for the sender

   file_uri_percent_decoder_core #(
      .HOST_MAX (HOST_CAP)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("ERROR @%0t:%s", $realtime, what);
   endtask

   // ---------------------------------------------------------------------
   // URI assembly
   // ---------------------------------------------------------------------

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) uri_q.push_back(fupd_pkg::char_type'(s[i]));
   endfunction

   function automatic fupd_pkg::char_type hex_char();
      return fupd_pkg::char_type'(HEX_DIGITS[$urandom_range(0, HEX_DIGITS.len() - 1)]);
   endfunction

   function automatic fupd_pkg::char_type odd_char();
      return fupd_pkg::char_type'(NON_HEX[$urandom_range(0, NON_HEX.len() - 1)]);
   endfunction

   // any nonzero byte, weighted toward printable path text
   function automatic fupd_pkg::char_type path_char();
      case ($urandom_range(0, 5))
         0:       return fupd_pkg::char_type'($urandom_range(1, 255));
         1:       return fupd_pkg::CH_SLASH;
         2:       return fupd_pkg::char_type'($urandom_range(fupd_pkg::CH_D0,
                                                             fupd_pkg::CH_D9));
         default: return fupd_pkg::char_type'($urandom_range(fupd_pkg::CH_LC_A, 8'h7A));
      endcase
   endfunction

   // host bytes never carry a slash or a zero
   function automatic fupd_pkg::char_type host_char();
      fupd_pkg::char_type c;
      case ($urandom_range(0, 4))
         0: begin
            c = fupd_pkg::char_type'($urandom_range(1, 255));
            if (c == fupd_pkg::CH_SLASH) c = fupd_pkg::CH_PCT;
         end
         1:       c = hex_char();
         default: c = fupd_pkg::char_type'($urandom_range(fupd_pkg::CH_LC_A, 8'h7A));
      endcase
      return c;
   endfunction

   function automatic void add_escape();
      uri_q.push_back(fupd_pkg::CH_PCT);
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            uri_q.push_back(hex_char());
            uri_q.push_back(hex_char());
         end
         3: begin
            uri_q.push_back(fupd_pkg::CH_D0);
            uri_q.push_back(fupd_pkg::CH_D0);
         end
         4: begin
            uri_q.push_back(odd_char());
            uri_q.push_back(path_char());
         end
         default: begin
            uri_q.push_back(hex_char());
            uri_q.push_back(odd_char());
         end
      endcase
   endfunction

   function automatic void add_path();
      repeat ($urandom_range(0, 10)) begin
         if ($urandom_range(0, 3) == 0) add_escape();
         else uri_q.push_back(path_char());
      end
   endfunction

   function automatic void add_host(input int n);
      repeat (n) uri_q.push_back(host_char());
   endfunction

   // Mostly well-formed file URIs with random content; the rest are cut-short
   // prefixes, bare paths and raw noise.
   function automatic void build_random_uri();
      int pick;
      int k;
      uri_q.delete();
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         add_text(SCHEME_TEXT);
         case ($urandom_range(0, 5))
            0, 1: begin
               add_text(LOCAL_TEXT);
               add_path();
            end
            2: begin
               // path already starts with a slash
               uri_q.push_back(fupd_pkg::CH_SLASH);
               add_path();
            end
            3: begin
               add_host($urandom_range(1, 8));
               uri_q.push_back(fupd_pkg::CH_SLASH);
               add_path();
            end
            4: begin
               // partial localhost: end here, slash, or turn into another host
               k = $urandom_range(1, fupd_pkg::LOCAL_LEN - 1);
               add_text(LOCAL_TEXT.substr(0, k - 1));
               case ($urandom_range(0, 2))
                  0: ;
                  1: begin
                     uri_q.push_back(fupd_pkg::CH_SLASH);
                     add_path();
                  end
                  default: begin
                     add_host($urandom_range(1, 4));
                     if ($urandom_range(0, 1) == 1) begin
                        uri_q.push_back(fupd_pkg::CH_SLASH);
                        add_path();
                     end
                  end
               endcase
            end
            default: begin
               // slashless host, sometimes around the buffer size
               if ($urandom_range(0, 3) == 0)
                  add_host($urandom_range(HOST_CAP - 2, HOST_CAP + 3));
               else
                  add_host($urandom_range(1, 10));
            end
         endcase
      end else if (pick < 16) begin
         k = $urandom_range(1, fupd_pkg::SCHEME_LEN - 1);
         add_text(SCHEME_TEXT.substr(0, k - 1));
         add_path();
      end else if (pick < 18) begin
         add_path();
      end else begin
         repeat ($urandom_range(1, 8))
            uri_q.push_back(fupd_pkg::char_type'($urandom_range(0, 255)));
      end
      // escape cut off by the end of the URI
      if (pick < 18 && $urandom_range(0, 5) == 0) begin
         uri_q.push_back(fupd_pkg::CH_PCT);
         if ($urandom_range(0, 1) == 1) uri_q.push_back(hex_char());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // One request beat. Valid stays up between back-to-back beats so it is
   // never dropped and raised in the same step.
   task automatic put_byte(input fupd_pkg::char_type b, input logic last);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_byte(b, last);
      req_beats++;
   endtask

   // Sends uri_q. The URI ends either on in_last with the final byte or on a
   // trailing NUL with in_last low.
   task automatic send_bytes(input bit nul_end);
      int n;
      if (nul_end || uri_q.size() == 0) uri_q.push_back(fupd_pkg::CH_NUL);
      n = uri_q.size();
      for (int i = 0; i < n; i++) put_byte(uri_q[i], (i == n - 1) && !nul_end);
   endtask

   task automatic send_text(input string s, input bit nul_end);
      uri_q.delete();
      add_text(s);
      send_bytes(nul_end);
   endtask

   task automatic send_random_uri();
      build_random_uri();
      req_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
         3:       send_bytes(1'b1);
         4: begin
            // NUL that also carries in_last
            uri_q.push_back(fupd_pkg::CH_NUL);
            send_bytes(1'b0);
         end
         default: send_bytes(1'b0);
      endcase
   endtask

   task automatic send_slashless_host(input int len);
      uri_q.delete();
      add_text(SCHEME_TEXT);
      add_host(len);
      send_bytes(1'b0);
   endtask

   // Holds the sender off until every expected beat is back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Register writes only with the core idle.
   task automatic write_out_limit(input logic [11:0] value);
      drain_results();
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.out_limit  = value;
   endtask

   task automatic random_phase();
      int goal;
      goal = req_beats + RANDOM_ITEMS / PHASES;
      while (req_beats < goal) begin
         if ($urandom_range(0, 14) == 0) drain_results();
         send_random_uri();
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, with stretches of full throughput
   // ---------------------------------------------------------------------
   initial begin
      int                     stall;
      fupd_pkg::rsp_item_type got;
      string                  msg;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got.out_byte   = rsp_chan.out_byte;
         got.byte_valid = rsp_chan.byte_valid;
         got.last_out   = rsp_chan.last_out;
         got.nonempty   = rsp_chan.nonempty;
         got.status     = rsp_chan.status;
         if (!sb.check_beat(got, msg)) report_mismatch($sformatf(" beat %0d%s", rsp_beats, msg));
         rsp_beats++;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: no beat on either channel for too long ends the run
   // ---------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      report_mismatch($sformatf(" no handshake for %0d cycles, %0d beats outstanding",
                                IDLE_LIMIT, sb.pending()));
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new();
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= fupd_pkg::CH_NUL;
      req_chan.in_last <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset length limit
      send_text("", 1'b1);              // lone NUL: empty URI
      put_byte(8'hFF, 1'b1);            // top byte value as a bare path
      send_text("fi", 1'b1);            // prefix cut short, ended by NUL
      send_text("%00", 1'b0);           // decoded zero up front
      send_text("%4g", 1'b0);           // bad escape
      send_text("%4", 1'b0);            // escape cut off after one digit
      send_text("%", 1'b0);             // escape cut off right away
      send_text("%aF", 1'b0);           // mixed-case hex digits
      send_text("file://loc", 1'b0);    // partial localhost at the end

      // Random phases over several limit settings, extremes included
      write_out_limit(12'd1);
      random_phase();

      write_out_limit(12'd4095);
      send_slashless_host(HOST_CAP);      // fills the host buffer exactly
      send_slashless_host(HOST_CAP + 1);  // one byte too many: dropped
      random_phase();

      write_out_limit(12'($urandom_range(2, 6)));
      random_phase();

      write_out_limit(fupd_pkg::MAX_OUT_RESET);
      random_phase();

      write_out_limit(12'($urandom_range(7, 40)));
      random_phase();

      drain_results();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (fail_count == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/fupd_pkg.sv
sv/fupd_if.sv
sv/fupd_dp.sv
sv/fupd_ctrl.sv
sv/file_uri_percent_decoder_core.sv
test/testbench.sv
